// ----- src/mxs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and helpers for the max stack.
// Used by the cell row, the result queue and the top level; depends on nothing.

package mxs_pkg;

  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 7;
  localparam int DEF_DEPTH = 64;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    ACT_PUSH    = 2'd0,
    ACT_POP     = 2'd1,
    ACT_POP_MAX = 2'd2,
    ACT_PEEK    = 2'd3
  } act_t;

  // Command broadcast to every cell of the row.
  typedef enum logic [2:0] {
    COP_HOLD  = 3'd0,
    COP_PUSH  = 3'd1,
    COP_POP   = 3'd2,
    COP_START = 3'd3,
    COP_SCAN  = 3'd4,
    COP_FIX   = 3'd5
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     seed;
    data_t    mval;
  } cell_cmd_t;

  // What one cell shows to its two neighbors.
  typedef struct packed {
    data_t val;
    data_t pmax;
    logic  srch;
    logic  shft;
    logic  fix;
  } link_t;

  typedef struct packed {
    data_t              removed;
    data_t              top;
    data_t              maxv;
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic               err;
  } result_t;

  function automatic data_t smax(data_t a, data_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ----- src/mxs_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// One stack cell: an entry and the largest value from this entry to the bottom.
// Depends on mxs_pkg.

module mxs_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mxs_pkg::cell_cmd_t cmd_i,
  input  wire logic [IDX_W-1:0]   base_i,
  input  wire mxs_pkg::link_t     up_i,
  input  wire mxs_pkg::link_t     dn_i,
  output mxs_pkg::link_t          link_o
);
  import mxs_pkg::*;

  data_t val_r, val_nxt;
  data_t pmax_r, pmax_nxt;
  logic  srch_r, srch_nxt;
  logic  shft_r, shft_nxt;
  logic  fix_r, fix_nxt;
  logic  match;
  logic  is_base;

  assign match   = (val_r == cmd_i.mval);
  assign is_base = (base_i == IDX_W'(IDX));

  assign link_o.val  = val_r;
  assign link_o.pmax = pmax_r;
  assign link_o.srch = srch_r & ~match;
  // Once the hunted copy is found, every cell below it takes its lower neighbor.
  assign link_o.shft = (srch_r & match) | shft_r;
  assign link_o.fix  = fix_r;

  always_comb begin
    val_nxt  = val_r;
    pmax_nxt = pmax_r;
    srch_nxt = 1'b0;
    shft_nxt = 1'b0;
    fix_nxt  = cmd_i.seed & is_base;
    unique case (cmd_i.op)
      COP_PUSH: begin
        val_nxt  = up_i.val;
        pmax_nxt = up_i.pmax;
      end
      COP_POP: begin
        val_nxt  = dn_i.val;
        pmax_nxt = dn_i.pmax;
      end
      COP_START: begin
        srch_nxt = up_i.srch;
      end
      COP_SCAN: begin
        srch_nxt = up_i.srch;
        shft_nxt = up_i.shft;
        if (link_o.shft) begin
          val_nxt = dn_i.val;
        end
      end
      COP_FIX: begin
        fix_nxt = dn_i.fix;
        if (fix_r) begin
          pmax_nxt = is_base ? val_r : smax(val_r, dn_i.pmax);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_r <= 1'b0;
      shft_r <= 1'b0;
      fix_r  <= 1'b0;
    end else begin
      srch_r <= srch_nxt;
      shft_r <= shft_nxt;
      fix_r  <= fix_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    pmax_r <= pmax_nxt;
  end

endmodule

`default_nettype wire

// ----- src/mxs_outq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Two-slot result queue: the output register and a holding register behind it.
// Depends on mxs_pkg.

module mxs_outq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_i,
  input  wire mxs_pkg::result_t data_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output mxs_pkg::result_t      data_o
);
  import mxs_pkg::*;

  logic    out_valid_r;
  logic    hold_valid_r;
  result_t out_r;
  result_t hold_r;
  logic    take;
  logic    out_free;

  assign take        = out_valid_r & ~out_stall_i;
  assign out_free    = ~out_valid_r | take;
  assign full_o      = hold_valid_r;
  assign out_valid_o = out_valid_r;
  assign data_o      = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= hold_valid_r | wr_i;
      hold_valid_r <= hold_valid_r & wr_i;
    end else if (wr_i) begin
      hold_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (hold_valid_r) begin
        out_r <= hold_r;
      end else if (wr_i) begin
        out_r <= data_i;
      end
    end
    if (wr_i && (hold_valid_r || !out_free)) begin
      hold_r <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> out_valid_r)
    else $error("holding slot is full while the output slot is empty");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_i |-> !(hold_valid_r && out_valid_r && out_stall_i))
    else $error("result written into a full queue");

  a_hold_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (take && hold_valid_r) |=> out_valid_r)
    else $error("held result was not moved to the output slot");
`endif

endmodule

`default_nettype wire

// ----- src/max_stack_with_pop_max.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Max stack top level: the row of cells, the sequencer and the result queue.
// Depends on mxs_pkg, mxs_cell and mxs_outq.
//
//   channel   handshake            payload
//   in_       in_valid, in_stall   in_action, in_push_value
//   out_      out_valid, out_stall out_removed_value, out_top_value, out_max_value,
//                                  out_entry_count, out_is_empty, out_error
//
// Cell 0 holds the top; push and pop shift the whole row by one place.
// Push, pop, peek and refused actions are taken back to back while the queue has room.
// Pop maximum sends a search token down the row, one cell a cycle, closing the gap,
// then a token walks back up rebuilding the maxima; in_stall is high meanwhile.
// Reset (rst_n low, synchronous) empties the stack; entries themselves are not cleared.
// A stalled output holds one result and queues a second; then in_stall rises.

module max_stack_with_pop_max #(
  parameter int STACK_DEPTH = mxs_pkg::DEF_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_action,
  input  wire logic signed [mxs_pkg::DATA_W-1:0] in_push_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [mxs_pkg::DATA_W-1:0] out_removed_value,
  output logic signed [mxs_pkg::DATA_W-1:0] out_top_value,
  output logic signed [mxs_pkg::DATA_W-1:0] out_max_value,
  output logic [mxs_pkg::COUNT_W-1:0]     out_entry_count,
  output logic                            out_is_empty,
  output logic                            out_error
);
  import mxs_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIX,
    S_PUB
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cyc_r, cyc_nxt;
  data_t            rem_r, rem_nxt;

  link_t            links [STACK_DEPTH];
  link_t            head;
  cell_cmd_t        cmd;
  logic [CNT_W-1:0] base_w;
  logic [IDX_W-1:0] base;
  logic             accept;
  logic             q_full;
  logic             q_wr;
  result_t          res;
  result_t          q_out;
  act_t             act;
  logic             empty;
  data_t            cur_top;
  data_t            cur_max;
  logic [STACK_DEPTH-1:0] tok_down;
  logic [STACK_DEPTH-1:0] tok_up;

  assign in_stall = (state_r != S_IDLE) | q_full;
  assign accept   = in_valid & ~in_stall;
  assign act      = act_t'(in_action);
  assign empty    = (count_r == '0);
  assign cur_top  = empty ? '0 : links[0].val;
  assign cur_max  = empty ? '0 : links[0].pmax;
  assign base_w   = count_r - CNT_W'(1);
  assign base     = base_w[IDX_W-1:0];

  genvar j;
  generate
    for (j = 0; j < STACK_DEPTH; j++) begin : g_cell
      link_t up_link;
      link_t dn_link;
      if (j == 0) begin : g_head
        assign up_link = head;
      end else begin : g_mid
        assign up_link = links[j-1];
      end
      if (j == STACK_DEPTH - 1) begin : g_tail
        assign dn_link = '0;
      end else begin : g_body
        assign dn_link = links[j+1];
      end
      mxs_cell #(
        .IDX   (j),
        .IDX_W (IDX_W)
      ) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_i  (cmd),
        .base_i (base),
        .up_i   (up_link),
        .dn_i   (dn_link),
        .link_o (links[j])
      );
      assign tok_down[j] = links[j].srch | links[j].shft;
      assign tok_up[j]   = links[j].fix;
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cyc_nxt   = cyc_r;
    rem_nxt   = rem_r;
    cmd.op    = COP_HOLD;
    cmd.seed  = 1'b0;
    cmd.mval  = rem_r;
    head.val  = in_push_value;
    head.pmax = empty ? in_push_value : smax(in_push_value, links[0].pmax);
    head.srch = 1'b0;
    head.shft = 1'b0;
    head.fix  = 1'b0;
    q_wr        = 1'b0;
    res.removed = '0;
    res.top     = cur_top;
    res.maxv    = cur_max;
    res.count   = COUNT_W'(count_r);
    res.empty   = empty;
    res.err     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          q_wr = 1'b1;
          unique case (act)
            ACT_PUSH: begin
              if (count_r == CNT_W'(STACK_DEPTH)) begin
                res.err = 1'b1;
              end else begin
                cmd.op    = COP_PUSH;
                count_nxt = count_r + CNT_W'(1);
                res.top   = in_push_value;
                res.maxv  = head.pmax;
                res.count = COUNT_W'(count_nxt);
                res.empty = 1'b0;
              end
            end
            ACT_POP: begin
              if (empty) begin
                res.err = 1'b1;
              end else begin
                cmd.op      = COP_POP;
                count_nxt   = count_r - CNT_W'(1);
                res.removed = links[0].val;
                res.empty   = (count_nxt == '0);
                res.top     = res.empty ? '0 : links[1].val;
                res.maxv    = res.empty ? '0 : links[1].pmax;
                res.count   = COUNT_W'(count_nxt);
              end
            end
            ACT_POP_MAX: begin
              if (empty) begin
                res.err = 1'b1;
              end else begin
                // The result goes out once the row has been rebuilt.
                q_wr      = 1'b0;
                cmd.op    = COP_START;
                head.srch = 1'b1;
                rem_nxt   = links[0].pmax;
                count_nxt = count_r - CNT_W'(1);
                cyc_nxt   = count_r - CNT_W'(1);
                state_nxt = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        cmd.op = COP_SCAN;
        if (cyc_r == '0) begin
          cmd.seed  = ~empty;
          cyc_nxt   = base_w;
          state_nxt = empty ? S_PUB : S_FIX;
        end else begin
          cyc_nxt = cyc_r - CNT_W'(1);
        end
      end
      S_FIX: begin
        cmd.op = COP_FIX;
        if (cyc_r == '0) begin
          state_nxt = S_PUB;
        end else begin
          cyc_nxt = cyc_r - CNT_W'(1);
        end
      end
      S_PUB: begin
        q_wr        = 1'b1;
        res.removed = rem_r;
        state_nxt   = S_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cyc_r   <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cyc_r   <= cyc_nxt;
      rem_r   <= rem_nxt;
    end
  end

  mxs_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_i        (q_wr),
    .data_i      (res),
    .full_o      (q_full),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .data_o      (q_out)
  );

  assign out_removed_value = q_out.removed;
  assign out_top_value     = q_out.top;
  assign out_max_value     = q_out.maxv;
  assign out_entry_count   = q_out.count;
  assign out_is_empty      = q_out.empty;
  assign out_error         = q_out.err;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("entry count exceeds the stack depth");

  a_one_down_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_down))
    else $error("more than one search token in the cell row");

  a_one_up_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_up))
    else $error("more than one rebuild token in the cell row");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (count_r == $past(count_r) || count_r == $past(count_r) + CNT_W'(1)
                || count_r == $past(count_r) - CNT_W'(1)))
    else $error("one transfer moved the entry count by more than one");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for max_stack_with_pop_max: directed and random actions,
// a cycle-accurate-free predictor of the stack and a scoreboard on the result channel.
// Depends on mxs_pkg and the max_stack_with_pop_max top level only.

module tb_top;
  import mxs_pkg::*;

  localparam int DEPTH       = 64;
  localparam int TOTAL_ITEMS = 1800;
  localparam int CYCLE_LIMIT = 1_200_000;

  logic  clk           = 1'b0;
  logic  rst_n         = 1'b0;
  logic  in_valid      = 1'b0;
  logic  [1:0] in_action = 2'd0;
  data_t in_push_value = '0;
  logic  out_stall     = 1'b0;

  logic               in_stall;
  logic               out_valid;
  data_t              out_removed_value;
  data_t              out_top_value;
  data_t              out_max_value;
  logic [COUNT_W-1:0] out_entry_count;
  logic               out_is_empty;
  logic               out_error;

  max_stack_with_pop_max #(
    .STACK_DEPTH(DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_removed_value(out_removed_value),
    .out_top_value    (out_top_value),
    .out_max_value    (out_max_value),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_error        (out_error)
  );

  always #5 clk = ~clk;

  // Predicted stack contents; slot 0 is the bottom.
  data_t   stack_mem [DEPTH];
  int      stack_fill = 0;
  result_t expected_q[$];

  bit idle_on    = 1'b1;
  int fail_count = 0;
  int sent_items = 0;
  int cycles     = 0;
  int stall_left = 0;
  int act_seen [4];
  int refused    = 0;
  int peak_fill  = 0;

  // Largest entry, taking the copy nearest the top on ties.
  function automatic int max_slot();
    int best;
    best = stack_fill - 1;
    for (int i = stack_fill - 2; i >= 0; i--) begin
      if (stack_mem[i] > stack_mem[best]) begin
        best = i;
      end
    end
    return best;
  endfunction

  function automatic result_t apply_action(act_t op, data_t val);
    result_t r;
    int      slot;
    r = '0;
    case (op)
      ACT_PUSH: begin
        if (stack_fill >= DEPTH) begin
          r.err = 1'b1;
        end else begin
          stack_mem[stack_fill] = val;
          stack_fill++;
        end
      end
      ACT_POP: begin
        if (stack_fill == 0) begin
          r.err = 1'b1;
        end else begin
          stack_fill--;
          r.removed = stack_mem[stack_fill];
        end
      end
      ACT_POP_MAX: begin
        if (stack_fill == 0) begin
          r.err = 1'b1;
        end else begin
          slot = max_slot();
          r.removed = stack_mem[slot];
          for (int i = slot; i < stack_fill - 1; i++) begin
            stack_mem[i] = stack_mem[i + 1];
          end
          stack_fill--;
        end
      end
      default: begin
      end
    endcase
    if (stack_fill == 0) begin
      r.empty = 1'b1;
    end else begin
      r.top  = stack_mem[stack_fill - 1];
      r.maxv = stack_mem[max_slot()];
    end
    r.count = COUNT_W'(stack_fill);
    return r;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%08h got 0x%08h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Predicts on every input transfer and scores every result transfer. Both live in
  // one block so a same-edge result can never overtake its own prediction.
  always @(posedge clk) begin : scoreboard
    result_t pred;
    result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pred = apply_action(act_t'(in_action), in_push_value);
        expected_q.insert(expected_q.size(), pred);
        act_seen[in_action]++;
        if (pred.err) begin
          refused++;
        end
        if (stack_fill > peak_fill) begin
          peak_fill = stack_fill;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, removed 0x%08h", $time,
                   out_removed_value);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("removed_value", want.removed, out_removed_value);
          check_field("top_value", want.top, out_top_value);
          check_field("max_value", want.maxv, out_max_value);
          check_field("entry_count", DATA_W'(want.count), DATA_W'(out_entry_count));
          check_field("is_empty", DATA_W'(want.empty), DATA_W'(out_is_empty));
          check_field("error", DATA_W'(want.err), DATA_W'(out_error));
        end
      end
    end
  end

  // Result-side backpressure: a fresh stall length is drawn after each transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        stall_left = idle_on ? $urandom_range(0, 8) : 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               expected_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Returns at the edge where the transfer happens; valid stays high for a
  // back-to-back follower.
  task automatic send_action(act_t op, data_t val);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= op;
    in_push_value <= val;
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  // Always waits for a clock edge before checking, so the last transfer is already
  // predicted and valid is never driven twice in one step.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0:       return data_t'(32'h8000_0000);
      1:       return data_t'(32'h7fff_ffff);
      2, 3, 4: return data_t'(int'($urandom_range(0, 8)) - 4);
      default: return data_t'($urandom);
    endcase
  endfunction

  // Mode 0 grows the stack, mode 1 shrinks it, mode 2 keeps it roughly level.
  function automatic act_t pick_action(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0:       return (r < 75) ? ACT_PUSH : (r < 85) ? ACT_POP :
                      (r < 95) ? ACT_POP_MAX : ACT_PEEK;
      1:       return (r < 15) ? ACT_PUSH : (r < 55) ? ACT_POP :
                      (r < 90) ? ACT_POP_MAX : ACT_PEEK;
      default: return (r < 40) ? ACT_PUSH : (r < 60) ? ACT_POP :
                      (r < 85) ? ACT_POP_MAX : ACT_PEEK;
    endcase
  endfunction

  task automatic test_empty_refusals();
    send_action(ACT_POP, 32'sd0);
    send_action(ACT_POP_MAX, 32'sd0);
    send_action(ACT_PEEK, -32'sd1);
  endtask

  task automatic test_extremes();
    send_action(ACT_PUSH, data_t'(32'h7fff_ffff));
    send_action(ACT_PUSH, data_t'(32'h8000_0000));
    send_action(ACT_PUSH, 32'sd0);
    send_action(ACT_PUSH, -32'sd1);
    send_action(ACT_PEEK, data_t'(32'h5555_aaaa));
    send_action(ACT_POP_MAX, 32'sd0);
    send_action(ACT_POP_MAX, 32'sd0);
    send_action(ACT_POP, 32'sd0);
    send_action(ACT_POP, 32'sd0);
  endtask

  // Two copies of the maximum: the upper one must go, so the pop order afterwards
  // tells which copy was removed.
  task automatic test_tie_order();
    send_action(ACT_PUSH, 32'sd7);
    send_action(ACT_PUSH, 32'sd2);
    send_action(ACT_PUSH, 32'sd7);
    send_action(ACT_PUSH, 32'sd1);
    send_action(ACT_POP_MAX, 32'sd0);
    send_action(ACT_POP, 32'sd0);
    send_action(ACT_POP, 32'sd0);
    send_action(ACT_POP, 32'sd0);
    send_action(ACT_POP_MAX, 32'sd0);
  endtask

  task automatic test_full_stack();
    repeat (DEPTH) send_action(ACT_PUSH, pick_value());
    send_action(ACT_PUSH, pick_value());
    send_action(ACT_PUSH, pick_value());
    send_action(ACT_PEEK, pick_value());
    repeat (3) send_action(ACT_POP_MAX, pick_value());
    while (stack_fill > 0) begin
      send_action(($urandom_range(0, 1) == 0) ? ACT_POP : ACT_POP_MAX, pick_value());
      if (expected_q.size() > 4) begin
        wait_drain();
      end
    end
    wait_drain();
  endtask

  // The sender holds off until every result is back, then goes on without gaps.
  task automatic test_drain_pause();
    repeat (10) send_action(ACT_PUSH, pick_value());
    wait_drain();
    idle_on = 1'b0;
    repeat (11) send_action(ACT_POP_MAX, pick_value());
    idle_on = 1'b1;
  endtask

  task automatic test_random_mix();
    int mode;
    while (sent_items < TOTAL_ITEMS) begin
      mode    = $urandom_range(0, 2);
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(20, 80)) send_action(pick_action(mode), pick_value());
      if ($urandom_range(0, 9) == 0) begin
        wait_drain();
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_refusals();
    test_extremes();
    test_tie_order();
    test_full_stack();
    test_drain_pause();
    test_random_mix();
    wait_drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d actions: %0d push, %0d pop, %0d pop-max, %0d peek; %0d refused.",
             sent_items, act_seen[0], act_seen[1], act_seen[2], act_seen[3], refused);
    $display("Deepest stack seen: %0d of %0d entries, %0d field mismatches.",
             peak_fill, DEPTH, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- max_stack_with_pop_max.f -----
src/mxs_pkg.sv
src/mxs_cell.sv
src/mxs_outq.sv
src/max_stack_with_pop_max.sv
sim/tb_top.sv
